@@ rtl/core/cpre_pkg.sv @@
// ----------------------------------------------------------------------------
// cpre_pkg
// Shared widths, constants and control types for the column peak/RMS envelope.
// ----------------------------------------------------------------------------
package cpre_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MAX_W    = 15;
	localparam int RMS_W    = 16;
	localparam int LOUD_W   = 16;
	localparam int REF_W    = 17;
	localparam int SQ_W     = 31;
	localparam int SUM_W    = 46;
	localparam int ROOT_W   = 32;
	localparam int FRAC_W   = 15;
	localparam int ITER_W   = 6;

	localparam logic [REF_W-1:0]  REF_RESET = REF_W'(16384);
	localparam logic [SUM_W-1:0]  SUM_LIMIT = {SUM_W{1'b1}};
	localparam logic [LOUD_W-1:0] ONE_Q15   = LOUD_W'(32768);
	localparam logic [ROOT_W-1:0] ROOT_TOP  = ROOT_W'(32'h4000_0000);

	localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(SUM_W - 1);
	localparam logic [ITER_W-1:0] ROOT_LAST = ITER_W'(ROOT_W / 2 - 1);

	typedef struct packed {
		logic load_in;
		logic square;
		logic accumulate;
		logic zero_result;
		logic div_load_mean;
		logic div_load_loud;
		logic div_step;
		logic root_load;
		logic root_step;
		logic rms_save;
		logic loud_save;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic column_end;
		logic count_zero;
		logic out_busy;
	} sts_t;

endpackage

@@ rtl/core/cpre_in_if.sv @@
// ----------------------------------------------------------------------------
// cpre_in_if
// Sample request channel: one optional sample and a column-close flag.
// ----------------------------------------------------------------------------
interface cpre_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [cpre_pkg::SAMPLE_W-1:0] sample;
	logic                                has_sample;
	logic                                column_end;

	modport source(output valid, output sample, output has_sample, output column_end,
		input ready);
	modport sink(input valid, input sample, input has_sample, input column_end,
		output ready);
endinterface

@@ rtl/core/cpre_out_if.sv @@
// ----------------------------------------------------------------------------
// cpre_out_if
// Column result channel: peak, trough, RMS, loudness and overflow.
// ----------------------------------------------------------------------------
interface cpre_out_if;
	logic                                valid;
	logic                                ready;
	logic        [cpre_pkg::MAX_W-1:0]    column_max;
	logic signed [cpre_pkg::SAMPLE_W-1:0] column_min;
	logic        [cpre_pkg::RMS_W-1:0]    rms_level;
	logic        [cpre_pkg::LOUD_W-1:0]   loudness;
	logic                                overflow;

	modport source(output valid, output column_max, output column_min, output rms_level,
		output loudness, output overflow, input ready);
	modport sink(input valid, input column_max, input column_min, input rms_level,
		input loudness, input overflow, output ready);
endinterface

@@ rtl/core/column_peak_rms_envelope.sv @@
// ----------------------------------------------------------------------------
// column_peak_rms_envelope
// Min/max/RMS envelope of one display column of Q1.15 audio.
// ----------------------------------------------------------------------------
// Requests arrive on audio (valid/ready): an optional sample and a flag that
// closes the column after it. Each request passes through capture, square and
// accumulate, and audio.ready stays low until the block is through with them.
// A request that closes the column then runs the mean divide on the
// shift-subtract divider, the square root (16 steps) and the loudness divide
// on the same divider, then hands off the result; the next request can be
// taken at the earliest in the same cycle as column.valid rises. An empty
// column skips the arithmetic.
// Results leave through a result register on column (valid/ready); the block
// takes new requests while a result waits. If the receiver stalls and a second
// close finishes, the sequencer holds that result until the register frees.
// User writes loudness_ref via loudness_ref_we/wdata while idle; not enforced.
// Reset clears the accumulators and sets loudness_ref to 0.5; no clearing pass.
// ----------------------------------------------------------------------------
module column_peak_rms_envelope #(
	parameter int MAX_COLUMN_SAMPLES = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	cpre_in_if.sink                       audio,
	cpre_out_if.source                    column,
	input  logic                          loudness_ref_we,
	input  logic [cpre_pkg::REF_W-1:0]    loudness_ref_wdata
);

	cpre_pkg::cmd_t cmd;
	cpre_pkg::sts_t sts;

	cpre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (audio.valid),
		.in_ready (audio.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpre_dp #(
		.MAX_COLUMN_SAMPLES (MAX_COLUMN_SAMPLES)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.sample             (audio.sample),
		.has_sample         (audio.has_sample),
		.column_end         (audio.column_end),
		.loudness_ref_we    (loudness_ref_we),
		.loudness_ref_wdata (loudness_ref_wdata),
		.out_valid          (column.valid),
		.out_ready          (column.ready),
		.column_max         (column.column_max),
		.column_min         (column.column_min),
		.rms_level          (column.rms_level),
		.loudness           (column.loudness),
		.overflow           (column.overflow)
	);

	logic [cpre_pkg::SAMPLE_W:0] min_mag;
	assign min_mag = (cpre_pkg::SAMPLE_W + 1)'(-$signed({column.column_min[cpre_pkg::SAMPLE_W-1],
		column.column_min}));

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		audio.valid && audio.ready |=> !audio.ready)
		else $error("request accepted while previous one still in work");

	a_loud_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		column.valid |-> column.loudness <= cpre_pkg::ONE_Q15)
		else $error("loudness above one");

	a_silent_loud: assert property (@(posedge clk) disable iff (!arst_n)
		column.valid && column.rms_level == '0 |-> column.loudness == '0)
		else $error("nonzero loudness for zero rms");

	a_rms_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		column.valid |-> (cpre_pkg::SAMPLE_W + 1)'(column.rms_level) <=
			(cpre_pkg::SAMPLE_W + 1)'(column.column_max) ||
			(cpre_pkg::SAMPLE_W + 1)'(column.rms_level) <= min_mag)
		else $error("rms above column peak magnitude");

endmodule

@@ rtl/core/cpre_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpre_ctrl
// Sequencer: sample update, then on column close the mean divide, square root,
// loudness divide (all skipped for an empty column) and result hand-off.
// ----------------------------------------------------------------------------
module cpre_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cpre_pkg::sts_t sts,
	output cpre_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SQUARE = 4'd1;
	localparam logic [3:0] S_ACCUM  = 4'd2;
	localparam logic [3:0] S_START  = 4'd3;
	localparam logic [3:0] S_DIVM   = 4'd4;
	localparam logic [3:0] S_RTLD   = 4'd5;
	localparam logic [3:0] S_ROOT   = 4'd6;
	localparam logic [3:0] S_RMS    = 4'd7;
	localparam logic [3:0] S_DVLD   = 4'd8;
	localparam logic [3:0] S_DIVL   = 4'd9;
	localparam logic [3:0] S_LOUD   = 4'd10;
	localparam logic [3:0] S_DONE   = 4'd11;

	logic [3:0]                  state_q;
	logic [3:0]                  state_d;
	logic [cpre_pkg::ITER_W-1:0] iter_q;
	logic                        looping;

	assign in_ready = (state_q == S_IDLE);
	assign looping  = (state_q == S_DIVM) || (state_q == S_ROOT) || (state_q == S_DIVL);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_SQUARE;
				end
			end
			S_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = S_ACCUM;
			end
			S_ACCUM: begin
				cmd.accumulate = 1'b1;
				state_d        = sts.column_end ? S_START : S_IDLE;
			end
			S_START: begin
				if (sts.count_zero) begin
					cmd.zero_result = 1'b1;
					state_d         = S_DONE;
				end else begin
					cmd.div_load_mean = 1'b1;
					state_d           = S_DIVM;
				end
			end
			S_DIVM: begin
				cmd.div_step = 1'b1;
				if (iter_q == cpre_pkg::DIV_LAST) state_d = S_RTLD;
			end
			S_RTLD: begin
				cmd.root_load = 1'b1;
				state_d       = S_ROOT;
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				if (iter_q == cpre_pkg::ROOT_LAST) state_d = S_RMS;
			end
			S_RMS: begin
				cmd.rms_save = 1'b1;
				state_d      = S_DVLD;
			end
			S_DVLD: begin
				cmd.div_load_loud = 1'b1;
				state_d           = S_DIVL;
			end
			S_DIVL: begin
				cmd.div_step = 1'b1;
				if (iter_q == cpre_pkg::DIV_LAST) state_d = S_LOUD;
			end
			S_LOUD: begin
				cmd.loud_save = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				// hold the finished column until the result register frees up
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			if (looping && state_d == state_q) iter_q <= iter_q + 1'b1;
			else iter_q <= '0;
		end
	end

endmodule

@@ rtl/core/cpre_dp.sv @@
// ----------------------------------------------------------------------------
// cpre_dp
// Datapath: accumulators, shared shift-subtract divider, digit-by-digit root
// and the result register.
// ----------------------------------------------------------------------------
module cpre_dp #(
	parameter int MAX_COLUMN_SAMPLES = 65536
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cpre_pkg::cmd_t                       cmd,
	output cpre_pkg::sts_t                       sts,
	input  logic signed [cpre_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 has_sample,
	input  logic                                 column_end,
	input  logic                                 loudness_ref_we,
	input  logic        [cpre_pkg::REF_W-1:0]    loudness_ref_wdata,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [cpre_pkg::MAX_W-1:0]    column_max,
	output logic signed [cpre_pkg::SAMPLE_W-1:0] column_min,
	output logic        [cpre_pkg::RMS_W-1:0]    rms_level,
	output logic        [cpre_pkg::LOUD_W-1:0]   loudness,
	output logic                                 overflow
);

	localparam int CntW = $clog2(MAX_COLUMN_SAMPLES + 1);
	localparam int DivW = (CntW > cpre_pkg::REF_W) ? CntW : cpre_pkg::REF_W;
	localparam logic [CntW-1:0] CountMax = CntW'(MAX_COLUMN_SAMPLES);

	// request capture
	logic signed [cpre_pkg::SAMPLE_W-1:0] sample_q;
	logic                                 has_q;
	logic                                 end_q;
	logic signed [2*cpre_pkg::SAMPLE_W-1:0] prod;
	logic [cpre_pkg::SQ_W-1:0]            sq_q;

	// column accumulators
	logic signed [cpre_pkg::SAMPLE_W-1:0] max_q;
	logic signed [cpre_pkg::SAMPLE_W-1:0] min_q;
	logic [cpre_pkg::SUM_W-1:0]           sum_q;
	logic [cpre_pkg::SUM_W:0]             sum_ext;
	logic [CntW-1:0]                      cnt_q;
	logic                                 sat_q;
	logic [cpre_pkg::REF_W-1:0]           ref_q;

	// divider and root
	logic [cpre_pkg::SUM_W-1:0]  dvd_q;
	logic [DivW-1:0]             rem_q;
	logic [DivW-1:0]             dvs_q;
	logic [DivW:0]               rem_sh;
	logic                        rem_ge;
	logic [cpre_pkg::ROOT_W-1:0] x_q;
	logic [cpre_pkg::ROOT_W-1:0] res_q;
	logic [cpre_pkg::ROOT_W-1:0] bit_q;
	logic [cpre_pkg::ROOT_W-1:0] trial;
	logic [cpre_pkg::RMS_W-1:0]  rms_q;
	logic [cpre_pkg::LOUD_W-1:0] loud_q;

	assign prod    = sample_q * sample_q;
	assign sum_ext = {1'b0, sum_q} + (cpre_pkg::SUM_W + 1)'(sq_q);
	assign rem_sh  = {rem_q, dvd_q[cpre_pkg::SUM_W-1]};
	assign rem_ge  = (rem_sh >= {1'b0, dvs_q});
	assign trial   = res_q + bit_q;

	assign sts.column_end = end_q;
	assign sts.count_zero = (cnt_q == '0);
	assign sts.out_busy   = out_valid && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q <= sample;
			has_q    <= has_sample;
			end_q    <= column_end;
		end
		if (cmd.square) sq_q <= prod[cpre_pkg::SQ_W-1:0];

		if (cmd.div_load_mean) begin
			dvd_q <= sum_q;
			rem_q <= '0;
			dvs_q <= DivW'(cnt_q);
		end else if (cmd.div_load_loud) begin
			dvd_q <= cpre_pkg::SUM_W'({rms_q, {cpre_pkg::FRAC_W{1'b0}}});
			rem_q <= '0;
			dvs_q <= DivW'(ref_q);
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[cpre_pkg::SUM_W-2:0], rem_ge};
			rem_q <= rem_ge ? DivW'(rem_sh - {1'b0, dvs_q}) : DivW'(rem_sh);
		end

		if (cmd.root_load) begin
			// quotient of the mean never exceeds one full-scale square
			x_q   <= dvd_q[cpre_pkg::ROOT_W-1:0];
			res_q <= '0;
			bit_q <= cpre_pkg::ROOT_TOP;
		end else if (cmd.root_step) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end

		if (cmd.zero_result) begin
			rms_q  <= '0;
			loud_q <= '0;
		end else begin
			if (cmd.rms_save) rms_q <= res_q[cpre_pkg::RMS_W-1:0];
			if (cmd.loud_save) begin
				// a zero reference yields an all-ones quotient, which clamps to one
				if (rms_q == '0) loud_q <= '0;
				else if (dvd_q > cpre_pkg::SUM_W'(cpre_pkg::ONE_Q15)) loud_q <= cpre_pkg::ONE_Q15;
				else loud_q <= dvd_q[cpre_pkg::LOUD_W-1:0];
			end
		end

		if (cmd.out_load) begin
			column_max <= max_q[cpre_pkg::MAX_W-1:0];
			column_min <= min_q;
			rms_level  <= rms_q;
			loudness   <= loud_q;
			overflow   <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q     <= '0;
			min_q     <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			sat_q     <= 1'b0;
			ref_q     <= cpre_pkg::REF_RESET;
			out_valid <= 1'b0;
		end else begin
			if (loudness_ref_we) ref_q <= loudness_ref_wdata;

			if (cmd.out_load) begin
				max_q <= '0;
				min_q <= '0;
				sum_q <= '0;
				cnt_q <= '0;
				sat_q <= 1'b0;
			end else if (cmd.accumulate && has_q) begin
				if (sample_q > max_q) max_q <= sample_q;
				if (sample_q < min_q) min_q <= sample_q;
				if (cnt_q >= CountMax) begin
					// column full: drop from sum and count
					sat_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (sum_ext[cpre_pkg::SUM_W]) begin
						sum_q <= cpre_pkg::SUM_LIMIT;
						sat_q <= 1'b1;
					end else begin
						sum_q <= sum_ext[cpre_pkg::SUM_W-1:0];
					end
				end
			end

			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

endmodule
